@@ design/wtcr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wtcr_pkg: shared types and constants for the wheel to click remapper
// Item layouts for both channels, command codes, button bit positions and
// the sizing constants of the wheel divider and the owed-click counter.
// ----------------------------------------------------------------------------
package wtcr_pkg;

  // Wheel divide: quotient = floor(delta / 2^DIV_SHIFT), range 0 .. 8
  localparam int DIV_SHIFT     = 2;
  // Owed clicks only grow while below this limit, range 1 .. 4096
  localparam int PENDING_LIMIT = 512;

  localparam int OWED_W    = 14;
  localparam int DELTA_W   = 16;
  localparam int BTN_W     = 4;
  localparam int MASK_W    = 3;
  localparam int REM_W     = (DIV_SHIFT == 0) ? 1 : DIV_SHIFT;
  localparam int SUM_W     = DELTA_W + 2;
  localparam int ADD_W     = SUM_W + 1;

  localparam logic [OWED_W-1:0] OWED_MAX  = {OWED_W{1'b1}};
  localparam logic [OWED_W-1:0] OWED_LIM  = OWED_W'(PENDING_LIMIT);
  localparam logic [REM_W-1:0]  REM_MASK  = REM_W'((1 << DIV_SHIFT) - 1);

  // Command codes
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Button bit positions
  localparam int BTN_LEFT   = 0;
  localparam int BTN_RIGHT  = 1;
  localparam int BTN_MIDDLE = 2;
  localparam int BTN_MACRO  = 3;

  // Click target codes
  localparam logic TGT_LEFT  = 1'b0;
  localparam logic TGT_RIGHT = 1'b1;

  localparam logic [MASK_W-1:0] MASK_LEFT  = 3'b001;
  localparam logic [MASK_W-1:0] MASK_RIGHT = 3'b010;
  localparam logic [MASK_W-1:0] MASK_NONE  = 3'b000;

  typedef struct packed {
    logic                      cmd;
    logic [BTN_W-1:0]          buttons;
    logic signed [DELTA_W-1:0] wheel_delta;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0]         button_mask;
    logic signed [DELTA_W-1:0] delta_out;
    logic                      mode_active;
  } out_item_t;

endpackage : wtcr_pkg
`default_nettype wire

@@ design/wheel_to_click_remapper.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wheel_to_click_remapper: turn wheel motion into left/right click pulses
// Update items track button edges, toggle remap mode on the macro button
// and fold divided wheel motion into an owed-click count; tick items pay
// the owed clicks out as press/release pulses of the chosen button.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------
//   in_     | input     | in_valid / in_ready    | in_item  (cmd, buttons, delta)
//   out_    | output    | out_valid / out_ready  | out_item (mask, delta, mode)
//
// One item per cycle sustained while out_ready stays high; each item's
// result passes through the input register, then the result register,
// before it is offered on out_valid.
// The remapper state is updated when an item moves from the input register
// into the result register, so items see state strictly in arrival order.
// A stalled result holds in the result register while one more item waits
// in the input register; in_ready drops only when both are full and
// out_ready is low.
// Reset (rst_n low, synchronous) clears mode, target, phase, edge memory,
// owed clicks, remainder and both valid flags.
// ----------------------------------------------------------------------------
module wheel_to_click_remapper (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire wtcr_pkg::in_item_t in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output wtcr_pkg::out_item_t     out_item
);
  import wtcr_pkg::*;

  // Pipeline registers
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      s1_adv;

  // Remapper state
  logic              remap_on_r,     remap_on_nxt;
  logic              click_target_r, click_target_nxt;
  logic              pulse_phase_r,  pulse_phase_nxt;
  logic              prev_macro_r,   prev_macro_nxt;
  logic              prev_middle_r,  prev_middle_nxt;
  logic              prev_left_r,    prev_left_nxt;
  logic              prev_right_r,   prev_right_nxt;
  logic [OWED_W-1:0] clicks_owed_r,  clicks_owed_nxt;
  logic [REM_W-1:0]  wheel_rem_r,    wheel_rem_nxt;
  out_item_t         result_nxt;

  // Datapath temporaries
  logic                    b_left, b_right, b_middle, b_macro;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] quot;
  logic [SUM_W-1:0]        abs_q;
  logic [ADD_W-1:0]        owed_add;

  // Handshake: the input register advances when the result slot frees up
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Capture accepted items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
  end

  // Compute next state and result for the item in the input register
  always_comb begin
    b_left   = s1_item_r.buttons[BTN_LEFT];
    b_right  = s1_item_r.buttons[BTN_RIGHT];
    b_middle = s1_item_r.buttons[BTN_MIDDLE];
    b_macro  = s1_item_r.buttons[BTN_MACRO];

    remap_on_nxt     = remap_on_r;
    click_target_nxt = click_target_r;
    pulse_phase_nxt  = pulse_phase_r;
    prev_macro_nxt   = prev_macro_r;
    prev_middle_nxt  = prev_middle_r;
    prev_left_nxt    = prev_left_r;
    prev_right_nxt   = prev_right_r;
    clicks_owed_nxt  = clicks_owed_r;
    wheel_rem_nxt    = wheel_rem_r;

    sum      = '0;
    quot     = '0;
    abs_q    = '0;
    owed_add = '0;

    result_nxt.button_mask = MASK_NONE;
    result_nxt.delta_out   = '0;

    if (s1_item_r.cmd == CMD_TICK) begin
      // Pay out owed clicks: press on one tick, release on the next
      if (!remap_on_r || clicks_owed_r == '0) begin
        pulse_phase_nxt = 1'b0;
      end else if (!pulse_phase_r) begin
        pulse_phase_nxt        = 1'b1;
        result_nxt.button_mask = (click_target_r == TGT_RIGHT) ? MASK_RIGHT : MASK_LEFT;
      end else begin
        pulse_phase_nxt = 1'b0;
        clicks_owed_nxt = clicks_owed_r - OWED_W'(1);
      end
    end else begin
      // Macro edge toggles the mode and drops all click bookkeeping
      if (b_macro && !prev_macro_r) begin
        remap_on_nxt     = !remap_on_r;
        click_target_nxt = TGT_LEFT;
        clicks_owed_nxt  = '0;
        wheel_rem_nxt    = '0;
        pulse_phase_nxt  = 1'b0;
      end

      // While middle held: tied edges pick right; tied at middle press, left wins
      if (remap_on_nxt) begin
        if (b_middle) begin
          if (b_left && !prev_left_r) click_target_nxt = TGT_LEFT;
          if (b_right && !prev_right_r) click_target_nxt = TGT_RIGHT;
        end
        if (b_middle && !prev_middle_r) begin
          if (b_right && !b_left) click_target_nxt = TGT_RIGHT;
          else if (b_left) click_target_nxt = TGT_LEFT;
        end
      end

      prev_macro_nxt  = b_macro;
      prev_middle_nxt = b_middle;
      prev_left_nxt   = b_left;
      prev_right_nxt  = b_right;

      if (!remap_on_nxt || s1_item_r.wheel_delta == '0) begin
        // Pass the item through, masking middle while remapping
        result_nxt.button_mask = s1_item_r.buttons[MASK_W-1:0];
        if (remap_on_nxt) result_nxt.button_mask[BTN_MIDDLE] = 1'b0;
        result_nxt.delta_out = s1_item_r.wheel_delta;
      end else begin
        // Consume the wheel: floor divide, keep remainder, grow owed count
        sum = {{(SUM_W-DELTA_W){s1_item_r.wheel_delta[DELTA_W-1]}},
               s1_item_r.wheel_delta}
            + {{(SUM_W-REM_W){1'b0}}, wheel_rem_nxt};
        quot          = sum >>> DIV_SHIFT;
        abs_q         = quot[SUM_W-1] ? SUM_W'(-quot) : SUM_W'(quot);
        wheel_rem_nxt = sum[REM_W-1:0] & REM_MASK;
        if (abs_q != '0 && clicks_owed_nxt < OWED_LIM) begin
          owed_add = {{(ADD_W-OWED_W){1'b0}}, clicks_owed_nxt}
                   + {{(ADD_W-SUM_W){1'b0}}, abs_q};
          clicks_owed_nxt = (owed_add > {{(ADD_W-OWED_W){1'b0}}, OWED_MAX})
                          ? OWED_MAX : owed_add[OWED_W-1:0];
        end
        result_nxt.button_mask = {1'b0, b_right, b_left};
      end
    end

    result_nxt.mode_active = remap_on_nxt;
  end

  // Commit state and load the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remap_on_r     <= 1'b0;
      click_target_r <= TGT_LEFT;
      pulse_phase_r  <= 1'b0;
      prev_macro_r   <= 1'b0;
      prev_middle_r  <= 1'b0;
      prev_left_r    <= 1'b0;
      prev_right_r   <= 1'b0;
      clicks_owed_r  <= '0;
      wheel_rem_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (s1_adv) begin
        remap_on_r     <= remap_on_nxt;
        click_target_r <= click_target_nxt;
        pulse_phase_r  <= pulse_phase_nxt;
        prev_macro_r   <= prev_macro_nxt;
        prev_middle_r  <= prev_middle_nxt;
        prev_left_r    <= prev_left_nxt;
        prev_right_r   <= prev_right_nxt;
        clicks_owed_r  <= clicks_owed_nxt;
        wheel_rem_r    <= wheel_rem_nxt;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (s1_adv) begin
      out_item_r <= result_nxt;
    end
  end

  // Owed clicks only exist while remapping
  a_owed_needs_mode: assert property (@(posedge clk) disable iff (!rst_n)
    !remap_on_r |-> (clicks_owed_r == '0))
    else $error("owed clicks present with remap mode off");

  // A pending release only exists while remapping
  a_phase_needs_mode: assert property (@(posedge clk) disable iff (!rst_n)
    pulse_phase_r |-> remap_on_r)
    else $error("pulse phase set with remap mode off");

  // A fresh result reports the mode that the state now holds
  a_mode_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $past(s1_adv && rst_n) |-> (out_item_r.mode_active == remap_on_r))
    else $error("result mode differs from committed mode");

  // Middle is never reported while remapping
  a_middle_masked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.mode_active) |-> !out_item_r.button_mask[BTN_MIDDLE])
    else $error("middle button reported in remap mode");

endmodule : wheel_to_click_remapper
`default_nettype wire
